// ===== src/csv_record_key_finder_assert.svh =====
// Assertion macros used by the RTL of the key finder.
// Each macro expects i_clk and i_rst_n in scope.
`ifndef CSV_RECORD_KEY_FINDER_ASSERT_SVH
`define CSV_RECORD_KEY_FINDER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define CSVKF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define CSVKF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/csvkf_pkg.sv =====
`default_nettype none

package csvkf_pkg;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_BYTE      = 2'd0,
        KIND_FIELD_END = 2'd1,
        KIND_DONE      = 2'd2
    } t_kind;

    // Key field parse phase
    typedef enum logic [1:0] {
        PH_BLANKS  = 2'd0,
        PH_DIGITS  = 2'd1,
        PH_STOPPED = 2'd2
    } t_phase;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_KEY_COLUMN = 1'b0,
        CFG_SEARCH_KEY = 1'b1
    } t_cfg_index;

    localparam int CFG_DATA_W   = 14;
    localparam int KEY_COL_W    = 4;
    localparam int KEY_VALUE_W  = 16;
    localparam int OUT_COLUMN_W = 4;

    localparam logic [7:0] CHAR_HASH    = 8'h23;
    localparam logic [7:0] CHAR_SEMI    = 8'h3B;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;

    localparam int FIRST_CAPTURED = 3;
    localparam int LAST_CAPTURED  = 8;

    localparam logic [KEY_VALUE_W-1:0] VALUE_MAX     = 16'hFFFF;
    localparam logic [KEY_VALUE_W-1:0] VALUE_MAX_D10 = 16'd6553;

    localparam logic [KEY_COL_W-1:0] KEY_COLUMN_RESET = 4'd1;

endpackage

`default_nettype wire

// ===== src/csvkf_in_if.sv =====
`default_nettype none

interface csvkf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_file;

    modport source (output valid, output in_byte, output end_of_file, input ready);
    modport sink   (input valid, input in_byte, input end_of_file, output ready);
endinterface

`default_nettype wire

// ===== src/csvkf_out_if.sv =====
`default_nettype none

interface csvkf_out_if;
    logic                                  valid;
    logic                                  ready;
    csvkf_pkg::t_kind                      result_kind;
    logic [csvkf_pkg::OUT_COLUMN_W-1:0]    column;
    logic [7:0]                            out_byte;
    logic                                  found;

    modport source (output valid, output result_kind, output column, output out_byte,
                    output found, input ready);
    modport sink   (input valid, input result_kind, input column, input out_byte,
                    input found, output ready);
endinterface

`default_nettype wire

// ===== src/csv_record_key_finder.sv =====
// Channel   Dir  Payload                               Accepted when
// i_item    in   in_byte[8], end_of_file[1]            valid && ready
// o_result  out  result_kind[2], column[4],            valid && ready
//                out_byte[8], found[1]
// i_cfg_*   in   index[1], data[14]                    i_cfg_we
//
// One input item per cycle unless the input stalls; its result (if any) appears in the output register
// on the following cycle. The output holds a single result register.
// The input stalls only while a result waits in that register and o_result.ready is low.
// Synchronous active-low reset: key_column = 1, search_key = 0, search restarted.
// Writing search_key restarts the search; after done, items are taken and dropped.
`default_nettype none

module csv_record_key_finder #(
    parameter int COLUMN_LIMIT = 15
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire csvkf_pkg::t_cfg_index          i_cfg_index,
    input  wire [csvkf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    csvkf_in_if.sink                            i_item,
    csvkf_out_if.source                         o_result
);

    localparam int COL_W = $clog2(COLUMN_LIMIT + 1);
    localparam int KV_W  = csvkf_pkg::KEY_VALUE_W;

    // Configuration
    logic [csvkf_pkg::KEY_COL_W-1:0] r_key_column;
    logic [csvkf_pkg::CFG_DATA_W-1:0] r_search_key;

    // Scan state
    logic                 r_skip, n_skip;
    logic                 r_matched, n_matched;
    logic                 r_empty, n_empty;
    logic [COL_W-1:0]     r_col, n_col;
    logic [KV_W-1:0]      r_kval, n_kval;
    logic                 r_kneg, n_kneg;
    csvkf_pkg::t_phase    r_phase, n_phase;
    logic                 r_fin, n_fin;

    // Result register
    logic                                r_out_valid;
    csvkf_pkg::t_kind                    r_out_kind;
    logic [csvkf_pkg::OUT_COLUMN_W-1:0]  r_out_col;
    logic [7:0]                          r_out_byte;
    logic                                r_out_found;

    logic                                res_valid;
    csvkf_pkg::t_kind                    res_kind;
    logic [csvkf_pkg::OUT_COLUMN_W-1:0]  res_col;
    logic [7:0]                          res_byte;
    logic                                res_found;

    logic             w_acc;
    logic             w_restart;
    logic [7:0]       w_c;
    logic             w_digit;
    logic             w_blank;
    logic             w_sep;
    logic             w_newline;
    logic             w_at_key;
    logic             w_key_match;
    logic             w_captured;
    logic [KV_W-1:0]  w_acc_val;
    logic [KV_W+3:0]  w_prod;

    assign i_item.ready = !r_out_valid || o_result.ready;
    assign w_acc        = i_item.valid && i_item.ready;
    assign w_restart    = i_cfg_we && (i_cfg_index == csvkf_pkg::CFG_SEARCH_KEY);

    // Classify the incoming byte
    assign w_c       = i_item.in_byte;
    assign w_digit   = (w_c >= csvkf_pkg::CHAR_ZERO) && (w_c <= csvkf_pkg::CHAR_NINE);
    assign w_blank   = (w_c == csvkf_pkg::CHAR_SPACE) ||
                       ((w_c >= csvkf_pkg::CHAR_TAB) && (w_c <= csvkf_pkg::CHAR_CR));
    assign w_newline = (w_c == csvkf_pkg::CHAR_NEWLINE);
    assign w_sep     = w_newline || (w_c == csvkf_pkg::CHAR_SEMI);
    assign w_at_key  = (r_col == COL_W'(r_key_column));
    assign w_captured = (r_col >= COL_W'(csvkf_pkg::FIRST_CAPTURED)) &&
                        (r_col <= COL_W'(csvkf_pkg::LAST_CAPTURED));

    // Compare the parsed key against the search key
    assign w_key_match = r_kneg ? ((r_kval == '0) && (r_search_key == '0))
                                : (r_kval == KV_W'(r_search_key));

    // Accumulate one decimal digit with saturation
    assign w_prod = {1'b0, r_kval, 3'b000} + {3'b000, r_kval, 1'b0}
                  + (KV_W+4)'(w_c - csvkf_pkg::CHAR_ZERO);
    assign w_acc_val = ((r_kval > csvkf_pkg::VALUE_MAX_D10) || (w_prod[KV_W+3:KV_W] != '0))
                       ? csvkf_pkg::VALUE_MAX : w_prod[KV_W-1:0];

    // Next scan state and result for the accepted item
    always_comb begin
        n_skip    = r_skip;
        n_matched = r_matched;
        n_empty   = r_empty;
        n_col     = r_col;
        n_kval    = r_kval;
        n_kneg    = r_kneg;
        n_phase   = r_phase;
        n_fin     = r_fin;
        res_valid = 1'b0;
        res_kind  = csvkf_pkg::KIND_BYTE;
        res_col   = '0;
        res_byte  = '0;
        res_found = 1'b0;
        if (w_acc && !r_fin) begin
            if (i_item.end_of_file) begin
                n_fin     = 1'b1;
                res_valid = 1'b1;
                res_kind  = csvkf_pkg::KIND_DONE;
                res_found = r_matched;
            end else if (r_empty && (w_c == csvkf_pkg::CHAR_HASH)) begin
                n_skip = 1'b1;
            end else if (r_skip) begin
                if (w_newline) begin
                    n_skip = 1'b0;
                    if (r_matched) begin
                        n_fin     = 1'b1;
                        res_valid = 1'b1;
                        res_kind  = csvkf_pkg::KIND_DONE;
                        res_found = 1'b1;
                    end else begin
                        n_empty = 1'b1;
                        n_col   = '0;
                        n_kval  = '0;
                        n_kneg  = 1'b0;
                        n_phase = csvkf_pkg::PH_BLANKS;
                    end
                end
            end else if (w_sep) begin
                n_empty = 1'b1;
                n_kval  = '0;
                n_kneg  = 1'b0;
                n_phase = csvkf_pkg::PH_BLANKS;
                if (!r_matched && w_at_key) begin
                    if (w_key_match) begin
                        n_matched = 1'b1;
                    end else if (!w_newline) begin
                        n_skip = 1'b1;
                    end
                end
                if (w_newline) begin
                    if (r_matched || (w_at_key && w_key_match)) begin
                        n_fin     = 1'b1;
                        res_valid = 1'b1;
                        res_kind  = csvkf_pkg::KIND_DONE;
                        res_found = 1'b1;
                    end else begin
                        n_col = '0;
                    end
                end else begin
                    if (r_col < COL_W'(COLUMN_LIMIT)) begin
                        n_col = r_col + 1'b1;
                    end
                    if (r_matched && w_captured) begin
                        res_valid = 1'b1;
                        res_kind  = csvkf_pkg::KIND_FIELD_END;
                        res_col   = r_col[csvkf_pkg::OUT_COLUMN_W-1:0];
                    end
                end
            end else begin
                n_empty = 1'b0;
                if (r_matched) begin
                    if (w_captured) begin
                        res_valid = 1'b1;
                        res_kind  = csvkf_pkg::KIND_BYTE;
                        res_col   = r_col[csvkf_pkg::OUT_COLUMN_W-1:0];
                        res_byte  = w_c;
                    end
                end else if (w_at_key) begin
                    case (r_phase)
                        csvkf_pkg::PH_BLANKS: begin
                            if (w_blank) begin
                                n_phase = csvkf_pkg::PH_BLANKS;
                            end else if ((w_c == csvkf_pkg::CHAR_PLUS) ||
                                         (w_c == csvkf_pkg::CHAR_MINUS)) begin
                                n_kneg  = (w_c == csvkf_pkg::CHAR_MINUS);
                                n_phase = csvkf_pkg::PH_DIGITS;
                            end else if (!w_digit) begin
                                n_phase = csvkf_pkg::PH_STOPPED;
                            end else begin
                                n_phase = csvkf_pkg::PH_DIGITS;
                                n_kval  = w_acc_val;
                            end
                        end
                        csvkf_pkg::PH_DIGITS: begin
                            if (w_digit) begin
                                n_kval = w_acc_val;
                            end else begin
                                n_phase = csvkf_pkg::PH_STOPPED;
                            end
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
            end
        end
    end

    // Scan state; a search key write restarts the scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_restart) begin
            r_skip    <= 1'b0;
            r_matched <= 1'b0;
            r_empty   <= 1'b1;
            r_col     <= '0;
            r_kval    <= '0;
            r_kneg    <= 1'b0;
            r_phase   <= csvkf_pkg::PH_BLANKS;
            r_fin     <= 1'b0;
        end else begin
            r_skip    <= n_skip;
            r_matched <= n_matched;
            r_empty   <= n_empty;
            r_col     <= n_col;
            r_kval    <= n_kval;
            r_kneg    <= n_kneg;
            r_phase   <= n_phase;
            r_fin     <= n_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_column <= csvkf_pkg::KEY_COLUMN_RESET;
            r_search_key <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                csvkf_pkg::CFG_KEY_COLUMN:
                    r_key_column <= i_cfg_data[csvkf_pkg::KEY_COL_W-1:0];
                csvkf_pkg::CFG_SEARCH_KEY:
                    r_search_key <= i_cfg_data;
                default: begin
                    r_search_key <= r_search_key;
                end
            endcase
        end
    end

    // Load a result, or drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_kind  <= res_kind;
            r_out_col   <= res_col;
            r_out_byte  <= res_byte;
            r_out_found <= res_found;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.result_kind = r_out_kind;
    assign o_result.column      = r_out_col;
    assign o_result.out_byte    = r_out_byte;
    assign o_result.found       = r_out_found;

`include "csv_record_key_finder_assert.svh"

    `CSVKF_ASSERT_NOW(a_done_clean,
        r_out_valid && (r_out_kind == csvkf_pkg::KIND_DONE),
        (r_out_col == '0) && (r_out_byte == '0), "done result carries column or byte")

    `CSVKF_ASSERT_NOW(a_field_needs_match,
        r_out_valid && (r_out_kind != csvkf_pkg::KIND_DONE),
        r_matched && !r_fin, "field result without a matched row")

    `CSVKF_ASSERT_NOW(a_found_only_done,
        r_out_valid && (r_out_kind != csvkf_pkg::KIND_DONE),
        !r_out_found && (r_out_col >= 4'd3) && (r_out_col <= 4'd8),
        "field result with found set or outside captured columns")

    `CSVKF_ASSERT_NOW(a_ready_when_empty, !r_out_valid, i_item.ready,
        "input stalled with empty result register")

    `CSVKF_ASSERT_NEXT(a_done_latches, res_valid && (res_kind == csvkf_pkg::KIND_DONE),
        r_fin || $past(w_restart), "done result without finishing the search")

endmodule

`default_nettype wire
